// File: rtl/mbps_pkg.sv
`default_nettype none
package mbps_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int COUNT_BITS  = 16;
  localparam int PAT_BYTES   = 32;
  localparam int ADDR_W      = 48;
  localparam int LEN_W       = 6;
  localparam int SKIP_W      = 5;
  localparam int LIMIT_W     = 16;
  localparam int CMP_W       = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam int CFG_AW      = 6;
  localparam int CFG_DW      = 64;

  localparam logic [2:0] REG_PAT0  = 3'd0;
  localparam logic [2:0] REG_PAT1  = 3'd1;
  localparam logic [2:0] REG_PAT2  = 3'd2;
  localparam logic [2:0] REG_PAT3  = 3'd3;
  localparam logic [2:0] REG_MASK  = 3'd4;
  localparam logic [2:0] REG_LEN   = 3'd5;
  localparam logic [2:0] REG_LIMIT = 3'd6;

  typedef struct packed {
    logic [PATTERN_MAX-1:0]   need;
    logic [PATTERN_MAX*8-1:0] pat;
    logic                     len_ok;
    logic [LEN_W-1:0]         len;
    logic [LEN_W-1:0]         len_m1;
    logic [LIMIT_W-1:0]       limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic [ADDR_W-1:0] byte_addr;
    logic              region_first;
    logic              search_start;
  } item_t;

endpackage
`default_nettype wire

// File: rtl/mbps_cfg.sv
`default_nettype none
module mbps_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [mbps_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire logic [mbps_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic      [mbps_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                                cfg_pready,
  output mbps_pkg::cfg_t                      cfg_o
);

  logic [63:0]                        pat_word_r [4];
  logic [31:0]                        mask_r;
  logic [mbps_pkg::LEN_W-1:0]         len_r;
  logic [mbps_pkg::LIMIT_W-1:0]       limit_r;
  mbps_pkg::cfg_t                     cfg_r;
  mbps_pkg::cfg_t                     cfg_nxt;
  logic [2:0]                         reg_idx;
  logic                               wr_en;
  logic [7:0]                         pbyte [mbps_pkg::PAT_BYTES];

  assign reg_idx    = cfg_paddr[5:3];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_o      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < 4; w++) pat_word_r[w] <= '0;
      mask_r  <= '0;
      len_r   <= '0;
      limit_r <= mbps_pkg::LIMIT_W'(3);
    end else if (wr_en) begin
      unique case (reg_idx)
        mbps_pkg::REG_PAT0:  pat_word_r[0] <= cfg_pwdata;
        mbps_pkg::REG_PAT1:  pat_word_r[1] <= cfg_pwdata;
        mbps_pkg::REG_PAT2:  pat_word_r[2] <= cfg_pwdata;
        mbps_pkg::REG_PAT3:  pat_word_r[3] <= cfg_pwdata;
        mbps_pkg::REG_MASK:  mask_r  <= cfg_pwdata[31:0];
        mbps_pkg::REG_LEN:   len_r   <= cfg_pwdata[mbps_pkg::LEN_W-1:0];
        mbps_pkg::REG_LIMIT: limit_r <= cfg_pwdata[mbps_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mbps_pkg::REG_PAT0:  cfg_prdata = pat_word_r[0];
      mbps_pkg::REG_PAT1:  cfg_prdata = pat_word_r[1];
      mbps_pkg::REG_PAT2:  cfg_prdata = pat_word_r[2];
      mbps_pkg::REG_PAT3:  cfg_prdata = pat_word_r[3];
      mbps_pkg::REG_MASK:  cfg_prdata = {32'd0, mask_r};
      mbps_pkg::REG_LEN:   cfg_prdata = {{(64-mbps_pkg::LEN_W){1'b0}}, len_r};
      mbps_pkg::REG_LIMIT: cfg_prdata = {{(64-mbps_pkg::LIMIT_W){1'b0}}, limit_r};
      default:             cfg_prdata = '0;
    endcase
  end

  // align pattern to window positions: window byte i faces pattern byte len-1-i
  always_comb begin
    logic [mbps_pkg::LEN_W-1:0] idx;
    for (int k = 0; k < mbps_pkg::PAT_BYTES; k++) begin
      pbyte[k] = pat_word_r[k/8][(k%8)*8 +: 8];
    end
    cfg_nxt        = '0;
    cfg_nxt.len    = len_r;
    cfg_nxt.len_m1 = len_r - mbps_pkg::LEN_W'(1);
    cfg_nxt.len_ok = (len_r != '0) && (len_r <= mbps_pkg::LEN_W'(mbps_pkg::PATTERN_MAX));
    cfg_nxt.limit  = (limit_r == '0) ? mbps_pkg::LIMIT_W'(1) : limit_r;
    for (int i = 0; i < mbps_pkg::PATTERN_MAX; i++) begin
      idx = len_r - mbps_pkg::LEN_W'(1) - mbps_pkg::LEN_W'(i);
      cfg_nxt.need[i]      = (mbps_pkg::LEN_W'(i) < len_r) && !mask_r[idx[4:0]];
      cfg_nxt.pat[i*8 +: 8] = pbyte[idx[4:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/mbps_match.sv
`default_nettype none
module mbps_match (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         load,
  input  wire mbps_pkg::item_t              item,
  input  wire mbps_pkg::cfg_t               cfg,
  output logic                              hit_o,
  output logic [mbps_pkg::ADDR_W-1:0]       hit_addr_o,
  output logic [15:0]                       count_o,
  output logic [mbps_pkg::ADDR_W-1:0]       first_addr_o,
  output logic                              first_found_o,
  output logic                              limit_o
);

  logic [7:0]                        win_r [mbps_pkg::PATTERN_MAX];
  logic [7:0]                        win_nxt [mbps_pkg::PATTERN_MAX];
  logic [mbps_pkg::LEN_W-1:0]        fill_r, fill_nxt, fill_base;
  logic [mbps_pkg::SKIP_W-1:0]       skip_r, skip_nxt, skip_base;
  logic [mbps_pkg::COUNT_BITS-1:0]   tot_r, tot_nxt, tot_base;
  logic [mbps_pkg::ADDR_W-1:0]       first_r, first_nxt, first_base;
  logic                              seen_r, seen_nxt, seen_base;
  logic [mbps_pkg::PATTERN_MAX-1:0]  eq;
  logic                              hit_nxt;
  logic [mbps_pkg::ADDR_W-1:0]       hit_addr_nxt;
  logic [mbps_pkg::CMP_W-1:0]        tot_base_x, tot_nxt_x, limit_x;

  always_comb begin
    win_nxt[0] = item.data_byte;
    for (int k = 1; k < mbps_pkg::PATTERN_MAX; k++) win_nxt[k] = win_r[k-1];
    for (int i = 0; i < mbps_pkg::PATTERN_MAX; i++) begin
      eq[i] = !cfg.need[i] || (win_nxt[i] == cfg.pat[i*8 +: 8]);
    end
  end

  always_comb begin
    tot_base   = item.search_start ? '0 : tot_r;
    first_base = item.search_start ? '0 : first_r;
    seen_base  = item.search_start ? 1'b0 : seen_r;
    fill_base  = item.region_first ? '0 : fill_r;
    skip_base  = item.region_first ? '0 : skip_r;
    fill_nxt   = (fill_base == mbps_pkg::LEN_W'(mbps_pkg::PATTERN_MAX)) ?
                 fill_base : fill_base + mbps_pkg::LEN_W'(1);
    tot_base_x = mbps_pkg::CMP_W'(tot_base);
    limit_x    = mbps_pkg::CMP_W'(cfg.limit);
    hit_nxt    = (skip_base == '0) && cfg.len_ok && (fill_nxt >= cfg.len) &&
                 (tot_base_x < limit_x) && (tot_base != '1) && (&eq);
    tot_nxt      = tot_base;
    first_nxt    = first_base;
    seen_nxt     = seen_base;
    hit_addr_nxt = '0;
    if (hit_nxt) begin
      hit_addr_nxt = item.byte_addr - mbps_pkg::ADDR_W'(cfg.len_m1);
      tot_nxt      = tot_base + mbps_pkg::COUNT_BITS'(1);
      skip_nxt     = cfg.len_m1[mbps_pkg::SKIP_W-1:0];
      if (!seen_base) begin
        first_nxt = hit_addr_nxt;
        seen_nxt  = 1'b1;
      end
    end else begin
      skip_nxt = (skip_base != '0) ? skip_base - mbps_pkg::SKIP_W'(1) : skip_base;
    end
    tot_nxt_x = mbps_pkg::CMP_W'(tot_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      skip_r  <= '0;
      tot_r   <= '0;
      first_r <= '0;
      seen_r  <= 1'b0;
      for (int k = 0; k < mbps_pkg::PATTERN_MAX; k++) win_r[k] <= '0;
    end else if (load) begin
      fill_r  <= fill_nxt;
      skip_r  <= skip_nxt;
      tot_r   <= tot_nxt;
      first_r <= first_nxt;
      seen_r  <= seen_nxt;
      for (int k = 0; k < mbps_pkg::PATTERN_MAX; k++) win_r[k] <= win_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hit_o         <= hit_nxt;
      hit_addr_o    <= hit_addr_nxt;
      count_o       <= tot_nxt_x[15:0];
      first_addr_o  <= first_nxt;
      first_found_o <= seen_nxt;
      limit_o       <= (tot_nxt_x >= limit_x);
    end
  end

  a_hit_sets_first: assert property (@(posedge clk) disable iff (!rst_n)
    (load && hit_nxt) |=> seen_r)
    else $error("match without first match recorded");

  a_skip_blocks_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !item.region_first && skip_r != '0) |-> !hit_nxt)
    else $error("match tested during overlap skip");

  a_hit_loads_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (load && hit_nxt) |=> (skip_r == $past(cfg.len_m1[mbps_pkg::SKIP_W-1:0])))
    else $error("overlap skip not loaded after match");

  a_hit_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (load && hit_nxt) |=> (tot_r == $past(tot_base) + mbps_pkg::COUNT_BITS'(1)))
    else $error("match not counted");

endmodule
`default_nettype wire

// File: rtl/masked_byte_pattern_scanner_unit.sv
`default_nettype none
// channel | dir | handshake             | payload
// in_     | in  | in_tvalid/in_tready   | tdata{byte_addr,data_byte} tuser{search_start,region_first}
// out_    | out | out_tvalid/out_tready | tdata{first_match_addr,match_count,match_addr}
//         |     |                       | tuser{limit_reached,first_found,match_here}
// cfg_    | in  | APB psel/penable      | 64-bit registers at 8*index
//
// One byte per cycle sustained while out_tready is high; each byte passes the input register, then the result register.
// The window compare is a single registered pass: input register, compare, result register.
// Synchronous active-low reset clears window fill, skip, counters and valid flags.
// A stalled output holds its result; the input register keeps taking bytes while it has room.
module masked_byte_pattern_scanner_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [55:0]                 in_tdata,   // data_byte[7:0], byte_addr[55:8]
  input  wire logic [1:0]                  in_tuser,   // region_first[0], search_start[1]
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [111:0]                     out_tdata,  // match_addr[47:0], match_count[63:48],
                                                       // first_match_addr[111:64]
  output logic [2:0]                       out_tuser,  // match_here[0], first_found[1],
                                                       // limit_reached[2]
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [mbps_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [mbps_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [mbps_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                             cfg_pready
);

  mbps_pkg::cfg_t                   cfg;
  mbps_pkg::item_t                  item_r;
  logic                             s1_v_r;
  logic                             out_v_r;
  logic                             load;
  logic                             hit;
  logic [mbps_pkg::ADDR_W-1:0]      hit_addr;
  logic [15:0]                      count;
  logic [mbps_pkg::ADDR_W-1:0]      first_addr;
  logic                             first_found;
  logic                             limit_hit;

  assign load       = s1_v_r && (!out_v_r || out_tready);
  assign in_tready  = !s1_v_r || load;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {first_addr, count, hit_addr};
  assign out_tuser  = {limit_hit, first_found, hit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) s1_v_r <= in_tvalid;
      if (load) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.data_byte    <= in_tdata[7:0];
      item_r.byte_addr    <= in_tdata[55:8];
      item_r.region_first <= in_tuser[0];
      item_r.search_start <= in_tuser[1];
    end
  end

  mbps_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  mbps_match u_match (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .item          (item_r),
    .cfg           (cfg),
    .hit_o         (hit),
    .hit_addr_o    (hit_addr),
    .count_o       (count),
    .first_addr_o  (first_addr),
    .first_found_o (first_found),
    .limit_o       (limit_hit)
  );

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !load) |=> s1_v_r)
    else $error("pending byte dropped");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |=> out_v_r)
    else $error("stalled result dropped");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_v_r)
    else $error("result register loaded without valid");

endmodule
`default_nettype wire
